// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the focus of expansion block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is ignored while reset is asserted.
`define FOE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion that is also checked during reset.
`define FOE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== sv/foe_lsq_pkg.sv =====
// Types, constants and codes of the focus of expansion block.
// No dependencies; every other module of the block imports it.
`timescale 1ns / 1ps
package foe_lsq_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int MUL_W      = 64;
  localparam int MUL_CNT_W  = $clog2(MUL_W + 1);
  localparam int WIDE_W     = 128;
  localparam int DIV_CNT_W  = $clog2(WIDE_W + 1);

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] flow_u;
    logic signed [15:0] flow_v;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] foe_x;
    logic signed [31:0] foe_y;
    logic               singular;
  } out_item_t;

  // Order of the six products of the solve.
  typedef enum logic [2:0] {
    P_VV_UU,
    P_UV_UV,
    P_UU_VB,
    P_UV_UB,
    P_UV_VB,
    P_VV_UB
  } prod_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M1,
    S_M2,
    S_ACC,
    S_MUL_GO,
    S_MUL_WAIT,
    S_CHK,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic      capture;
    logic      mul1;
    logic      mul2;
    logic      accum;
    logic      mul_start;
    prod_sel_t sel;
    logic      div_start;
    logic      div_y;
    logic      out_load;
    logic      clear;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic mul_done;
    logic div_done;
    logic singular;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== sv/foe_lsq_mul.sv =====
// Shift-and-add signed multiplier, one partial product bit per cycle.
// Depends on foe_lsq_pkg.
`timescale 1ns / 1ps
module foe_lsq_mul (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic signed [foe_lsq_pkg::MUL_W-1:0]    op_a,
  input  logic signed [foe_lsq_pkg::MUL_W-1:0]    op_b,
  output logic                                    done,
  output logic signed [foe_lsq_pkg::WIDE_W-1:0]   prod
);
  import foe_lsq_pkg::*;

  logic [WIDE_W-1:0]        ma_r;
  logic [MUL_W-1:0]         mb_r;
  logic [WIDE_W-1:0]        acc_r;
  logic                     neg_r;
  logic [MUL_CNT_W-1:0]     cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic signed [WIDE_W-1:0] prod_r;
  logic [MUL_W-1:0]         mag_a;
  logic [MUL_W-1:0]         mag_b;
  logic                     last_step;

  assign mag_a     = op_a[MUL_W-1] ? MUL_W'(-op_a) : MUL_W'(op_a);
  assign mag_b     = op_b[MUL_W-1] ? MUL_W'(-op_b) : MUL_W'(op_b);
  assign last_step = (cnt_r == MUL_CNT_W'(MUL_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= {{(WIDE_W - MUL_W){1'b0}}, mag_a};
      mb_r  <= mag_b;
      acc_r <= '0;
      neg_r <= op_a[MUL_W-1] ^ op_b[MUL_W-1];
    end else if (busy_r) begin
      if (last_step) begin
        prod_r <= neg_r ? $signed(-acc_r) : $signed(acc_r);
      end else begin
        if (mb_r[0]) begin
          acc_r <= acc_r + ma_r;
        end
        ma_r <= ma_r << 1;
        mb_r <= mb_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== sv/foe_lsq_div.sv =====
// Restoring signed divider with truncation toward zero and 32-bit saturation.
// Depends on foe_lsq_pkg.
`timescale 1ns / 1ps
module foe_lsq_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [foe_lsq_pkg::WIDE_W-1:0] num,
  input  logic signed [foe_lsq_pkg::WIDE_W-1:0] den,
  output logic                                  done,
  output logic signed [31:0]                    quot
);
  import foe_lsq_pkg::*;

  logic [WIDE_W-1:0]    nm_r;
  logic [WIDE_W-1:0]    dm_r;
  logic [WIDE_W-1:0]    rem_r;
  logic [WIDE_W-1:0]    q_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic signed [31:0]   quot_r;
  logic [WIDE_W:0]      rem_s;
  logic [WIDE_W:0]      diff;
  logic                 ge;
  logic                 last_step;
  logic                 q_big;

  assign rem_s     = {rem_r, nm_r[WIDE_W-1]};
  assign diff      = rem_s - {1'b0, dm_r};
  assign ge        = (rem_s >= {1'b0, dm_r});
  assign last_step = (cnt_r == DIV_CNT_W'(WIDE_W));
  assign q_big     = (q_r[WIDE_W-1:31] != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nm_r  <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
      dm_r  <= den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= num[WIDE_W-1] ^ den[WIDE_W-1];
    end else if (busy_r) begin
      if (last_step) begin
        if (neg_r) begin
          quot_r <= q_big ? SAT_MIN : $signed(32'(-q_r[31:0]));
        end else begin
          quot_r <= q_big ? SAT_MAX : $signed(q_r[31:0]);
        end
      end else begin
        // The remainder stays below the divisor, so its top bit can be dropped.
        rem_r <= ge ? diff[WIDE_W-1:0] : rem_s[WIDE_W-1:0];
        q_r   <= {q_r[WIDE_W-2:0], ge};
        nm_r  <= nm_r << 1;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== sv/foe_lsq_dp.sv =====
// Datapath: point products, normal-equation sums, solve operands and result register.
// Depends on foe_lsq_pkg, foe_lsq_mul and foe_lsq_div.
`timescale 1ns / 1ps
module foe_lsq_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  foe_lsq_pkg::in_item_t   in_data,
  input  foe_lsq_pkg::dp_cmd_t    cmd,
  output foe_lsq_pkg::dp_stat_t   stat,
  input  logic                    out_stall,
  output logic                    out_valid,
  output foe_lsq_pkg::out_item_t  out_data
);
  import foe_lsq_pkg::*;

  in_item_t             in_r;
  logic signed [31:0]   vv_r;
  logic signed [31:0]   uu_r;
  logic signed [31:0]   uv_r;
  logic signed [33:0]   b_r;
  logic signed [49:0]   vb_r;
  logic signed [49:0]   ub_r;
  logic [40:0]          sum_vv_r;
  logic [40:0]          sum_uu_r;
  logic [41:0]          sum_uv_r;
  logic [59:0]          sum_vb_r;
  logic [59:0]          sum_ub_r;
  logic [CNT_W-1:0]     cnt_r;
  logic signed [WIDE_W-1:0] p0_r;
  logic signed [WIDE_W-1:0] det_r;
  logic signed [WIDE_W-1:0] nx_r;
  logic signed [WIDE_W-1:0] ny_r;
  logic signed [31:0]   qx_r;
  logic signed [31:0]   qy_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic signed [32:0]   vx_c;
  logic signed [32:0]   yu_c;
  logic signed [33:0]   b_c;
  logic signed [MUL_W-1:0] svv;
  logic signed [MUL_W-1:0] suu;
  logic signed [MUL_W-1:0] suv;
  logic signed [MUL_W-1:0] svb;
  logic signed [MUL_W-1:0] sub;
  logic signed [MUL_W-1:0] op_a;
  logic signed [MUL_W-1:0] op_b;
  logic                 mul_done;
  logic signed [WIDE_W-1:0] prod;
  logic                 div_done;
  logic signed [31:0]   quot;
  logic                 singular;

  assign vx_c = in_r.flow_v * $signed({1'b0, in_r.pos_x});
  assign yu_c = in_r.flow_u * $signed({1'b0, in_r.pos_y});
  assign b_c  = {vx_c[32], vx_c} - {yu_c[32], yu_c};

  assign svv = $signed({{(MUL_W - 41){1'b0}}, sum_vv_r});
  assign suu = $signed({{(MUL_W - 41){1'b0}}, sum_uu_r});
  assign suv = $signed({{(MUL_W - 42){sum_uv_r[41]}}, sum_uv_r});
  assign svb = $signed({{(MUL_W - 60){sum_vb_r[59]}}, sum_vb_r});
  assign sub = $signed({{(MUL_W - 60){sum_ub_r[59]}}, sum_ub_r});

  always_comb begin
    case (cmd.sel)
      P_VV_UU: begin op_a = svv; op_b = suu; end
      P_UV_UV: begin op_a = suv; op_b = suv; end
      P_UU_VB: begin op_a = suu; op_b = svb; end
      P_UV_UB: begin op_a = suv; op_b = sub; end
      P_UV_VB: begin op_a = suv; op_b = svb; end
      P_VV_UB: begin op_a = svv; op_b = sub; end
      default: begin op_a = '0;  op_b = '0;  end
    endcase
  end

  foe_lsq_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .op_a  (op_a),
    .op_b  (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  foe_lsq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_y ? ny_r : nx_r),
    .den   (det_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign singular = (cnt_r < CNT_W'(2)) || (det_r == '0);

  // Point products; each stage's products are registered before the next multiply.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.mul1) begin
      vv_r <= in_r.flow_v * in_r.flow_v;
      uu_r <= in_r.flow_u * in_r.flow_u;
      uv_r <= in_r.flow_u * in_r.flow_v;
      b_r  <= b_c;
    end
    if (cmd.mul2) begin
      vb_r <= in_r.flow_v * b_r;
      ub_r <= in_r.flow_u * b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vv_r <= '0;
      sum_uu_r <= '0;
      sum_uv_r <= '0;
      sum_vb_r <= '0;
      sum_ub_r <= '0;
      cnt_r    <= '0;
    end else if (cmd.clear) begin
      sum_vv_r <= '0;
      sum_uu_r <= '0;
      sum_uv_r <= '0;
      sum_vb_r <= '0;
      sum_ub_r <= '0;
      cnt_r    <= '0;
    end else if (cmd.accum && (cnt_r < CNT_W'(MAX_POINTS))) begin
      sum_vv_r <= sum_vv_r + {9'b0, vv_r};
      sum_uu_r <= sum_uu_r + {9'b0, uu_r};
      sum_uv_r <= sum_uv_r + {{10{uv_r[31]}}, uv_r};
      sum_vb_r <= sum_vb_r + {{10{vb_r[49]}}, vb_r};
      sum_ub_r <= sum_ub_r + {{10{ub_r[49]}}, ub_r};
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  // Products arrive in pairs; the second of each pair forms a difference.
  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.sel)
        P_UV_UV: det_r <= p0_r - prod;
        P_UV_UB: nx_r  <= p0_r - prod;
        P_VV_UB: ny_r  <= p0_r - prod;
        default: p0_r  <= prod;
      endcase
    end
    if (div_done) begin
      if (cmd.div_y) begin
        qy_r <= quot;
      end else begin
        qx_r <= quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.foe_x    <= singular ? '0 : qx_r;
      out_data_r.foe_y    <= singular ? '0 : qy_r;
      out_data_r.singular <= singular;
    end
  end

  assign stat.last     = in_r.last_point;
  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.singular = singular;
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/foe_lsq_ctrl.sv =====
// Controller state machine: sequences accumulation, the six products and two divides.
// Depends on foe_lsq_pkg.
`timescale 1ns / 1ps
module foe_lsq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  ready,
  input  foe_lsq_pkg::dp_stat_t stat,
  output foe_lsq_pkg::dp_cmd_t  cmd
);
  import foe_lsq_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  prod_sel_t   sel_r;
  prod_sel_t   sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= P_VV_UU;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    ready         = 1'b0;
    case (state_r)
      S_IDLE: begin
        ready       = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        sel_nxt   = P_VV_UU;
        state_nxt = stat.last ? S_MUL_GO : S_IDLE;
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (stat.mul_done) begin
          if (sel_r == P_VV_UB) begin
            state_nxt = S_CHK;
          end else begin
            sel_nxt   = prod_sel_t'(sel_r + 3'd1);
            state_nxt = S_MUL_GO;
          end
        end
      end
      S_CHK: begin
        state_nxt = stat.singular ? S_DONE : S_DIVX_GO;
      end
      S_DIVX_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVX_WAIT;
      end
      S_DIVX_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_DIVY_GO;
        end
      end
      S_DIVY_GO: begin
        cmd.div_y     = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVY_WAIT;
      end
      S_DIVY_WAIT: begin
        cmd.div_y = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Wait until the result register is free or being emptied this cycle.
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/focus_of_expansion_lsq.sv =====
// Focus of expansion by least squares over a stream of optical-flow points.
// Each point passes through an input register, a stage of point products, a stage
// of products with the right side, and the update of the normal-equation sums.
// A point marked last then starts the solve: six products on one shared
// shift-and-add multiplier and two divides on one restoring divider; a singular
// set skips the divides. New points are taken while a finished result waits
// at the output.
// Depends on foe_lsq_pkg, foe_lsq_ctrl and foe_lsq_dp.
`timescale 1ns / 1ps
module focus_of_expansion_lsq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  foe_lsq_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output foe_lsq_pkg::out_item_t out_data
);
  import foe_lsq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ready;

  foe_lsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .ready    (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  foe_lsq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign in_stall = !ready;

endmodule

// ===== sv/foe_lsq_chk.sv =====
// Port-level checker for the focus of expansion block, bound to the top level.
// Depends on foe_lsq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module foe_lsq_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input foe_lsq_pkg::out_item_t out_data
);
  import foe_lsq_pkg::*;

  `FOE_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  `FOE_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data))
  `FOE_ASSERT(a_busy_after_in, clk, rst_n, in_valid && !in_stall |=> in_stall)
  `FOE_ASSERT(a_singular_zero, clk, rst_n, out_valid && out_data.singular |-> out_data.foe_x == '0 && out_data.foe_y == '0)
  `FOE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind focus_of_expansion_lsq foe_lsq_chk u_foe_lsq_chk (.*);

// ===== dv/focus_of_expansion_lsq_tb.sv =====
// Self-checking testbench for focus_of_expansion_lsq: streams flow points, predicts each
// focus of expansion with an exact 128-bit solve and checks every result transaction.
// Depends on foe_lsq_pkg and focus_of_expansion_lsq.
`timescale 1ns / 1ps
module focus_of_expansion_lsq_tb;
  import foe_lsq_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SOLVE_WAIT = 800;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  focus_of_expansion_lsq dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Normal-equation sums as the block should hold them.
  logic [40:0] acc_vv, acc_uu;
  logic [41:0] acc_uv;
  logic [59:0] acc_vb, acc_ub;
  int          acc_points;

  out_item_t foe_queue[$];
  int        errors = 0;
  int        points_sent = 0;
  int        solves_checked = 0;
  int        singular_seen = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_req = 0;
  int        hold_left = 0;
  int        idle_cycles = 0;

  function automatic logic [31:0] div_sat(logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sd2147483647) return SAT_MAX;
    if (q < -128'sd2147483648) return SAT_MIN;
    return q[31:0];
  endfunction

  task automatic accumulate_point(in_item_t it);
    longint xs, ys, us, vs, b;
    out_item_t r;
    logic signed [127:0] svv, suu, suv, svb, sub, det, nx, ny;
    xs = longint'(it.pos_x);
    ys = longint'(it.pos_y);
    us = longint'(it.flow_u);
    vs = longint'(it.flow_v);
    if (acc_points < MAX_POINTS) begin
      b = vs * xs - ys * us;
      acc_vv += 41'(vs * vs);
      acc_uu += 41'(us * us);
      acc_uv += 42'(us * vs);
      acc_vb += 60'(vs * b);
      acc_ub += 60'(us * b);
      acc_points++;
    end
    if (!it.last_point) return;
    svv = {87'b0, acc_vv};
    suu = {87'b0, acc_uu};
    suv = $signed(acc_uv);
    svb = $signed(acc_vb);
    sub = $signed(acc_ub);
    det = svv * suu - suv * suv;
    if (acc_points < 2 || det == 0) begin
      r = '{foe_x: '0, foe_y: '0, singular: 1'b1};
    end else begin
      nx = suu * svb - suv * sub;
      ny = suv * svb - svv * sub;
      r = '{foe_x: div_sat(nx, det), foe_y: div_sat(ny, det), singular: 1'b0};
    end
    foe_queue.push_back(r);
    clear_sums();
  endtask

  function automatic void clear_sums();
    acc_vv = '0; acc_uu = '0; acc_uv = '0; acc_vb = '0; acc_ub = '0;
    acc_points = 0;
  endfunction

  // Drives one point and returns at the rising edge where it is taken.
  task automatic send_point(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_data = in_item_t'({$urandom, $urandom, $urandom});
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    accumulate_point(it);
    points_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    go_idle();
    while (foe_queue.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t rand_point(bit last);
    in_item_t it;
    it.pos_x = 16'($urandom);
    it.pos_y = 16'($urandom);
    it.flow_u = 16'($urandom);
    it.flow_v = 16'($urandom);
    // Small flows are more typical and keep the determinant well conditioned.
    if ($urandom_range(2) == 0) begin
      it.flow_u = $signed(16'($urandom_range(1023))) - 16'sd512;
      it.flow_v = $signed(16'($urandom_range(1023))) - 16'sd512;
    end
    it.last_point = last;
    return it;
  endfunction

  function automatic in_item_t mk(int x, int y, int u, int v, bit last);
    return '{pos_x: 16'(x), pos_y: 16'(y), flow_u: 16'(u), flow_v: 16'(v), last_point: last};
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (foe_queue.size() == 0) begin
        $error("unexpected result transaction foe_x=%0d foe_y=%0d singular=%0b",
               out_data.foe_x, out_data.foe_y, out_data.singular);
        errors++;
      end else begin
        out_item_t e;
        e = foe_queue.pop_front();
        if (out_data.foe_x !== e.foe_x) begin
          $error("foe_x expected %0d actual %0d", e.foe_x, out_data.foe_x);
          errors++;
        end
        if (out_data.foe_y !== e.foe_y) begin
          $error("foe_y expected %0d actual %0d", e.foe_y, out_data.foe_y);
          errors++;
        end
        if (out_data.singular !== e.singular) begin
          $error("singular expected %0b actual %0b", e.singular, out_data.singular);
          errors++;
        end
        solves_checked++;
        if (e.singular) singular_seen++;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", IDLE_LIMIT);
      $display("focus_of_expansion_lsq_tb NOT OK");
      $finish;
    end
  end

  task automatic test_directed();
    send_point(mk(16'hffff, 16'hffff, -32768, 32767, 1'b1));   // single point
    send_point(mk(100, 200, 256, 256, 1'b0));                   // parallel flows
    send_point(mk(300, 50, 256, 256, 1'b1));
    send_point(mk(0, 0, 0, 0, 1'b1));                           // zero flow
    send_point(mk(16'hffff, 0, 32767, 32767, 1'b0));
    send_point(mk(0, 16'hffff, -32768, 32767, 1'b0));
    send_point(mk(16'hffff, 16'hffff, 32767, -32768, 1'b0));
    send_point(mk(0, 0, -32768, -32768, 1'b1));
    // Radial flow around (160, 120) pixels.
    send_point(mk(2560 + 800, 1920, 512, 0, 1'b0));
    send_point(mk(2560, 1920 + 800, 0, 512, 1'b0));
    send_point(mk(2560 - 800, 1920 - 800, -512, -512, 1'b0));
    send_point(mk(2560 + 400, 1920 - 400, 256, -256, 1'b1));
    // Nearly parallel flows push the quotient into saturation.
    send_point(mk(0, 0, 32767, 32766, 1'b0));
    send_point(mk(16'hffff, 0, 32766, 32765, 1'b1));
    send_point(mk(16'hffff, 16'hffff, -1, 1, 1'b0));
    send_point(mk(0, 0, 1, 1, 1'b1));
    wait_drained();
  endtask

  // Points beyond the count limit are dropped; the last mark still solves.
  task automatic test_point_limit();
    int n;
    for (n = 0; n < MAX_POINTS + 3; n++) send_point(rand_point(1'b0));
    send_point(rand_point(1'b1));
    wait_drained();
  endtask

  task automatic test_random_sets(int n_items);
    int sent, len, k, kind;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(12, 2);
      kind = $urandom_range(9);
      if (kind == 0) len = 1;
      it = rand_point(1'b0);
      for (k = 0; k < len; k++) begin
        // Degenerate sets repeat one flow vector, so the determinant is zero.
        if (kind == 1) begin
          it.pos_x = 16'($urandom);
          it.pos_y = 16'($urandom);
        end else begin
          it = rand_point(1'b0);
        end
        it.last_point = (k == len - 1);
        send_point(it);
        sent++;
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    int k;
    hold_req = 3000;
    for (k = 0; k < 40; k++) send_point(rand_point(k % 2 == 1));
    // Pause until every outstanding solve has been delivered.
    wait_drained();
    for (k = 0; k < 6; k++) send_point(rand_point(k == 5));
    wait_drained();
  endtask

  initial begin
    clear_sums();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_point_limit();
    send_idle_pct = 0;  stall_pct = 0;  test_random_sets(12);
    send_idle_pct = 59; stall_pct = 0;  test_random_sets(12);
    send_idle_pct = 0;  stall_pct = 59; test_random_sets(12);
    send_idle_pct = 35; stall_pct = 35; test_random_sets(12);
    send_idle_pct = 0;  stall_pct = 0;  test_backpressure();

    go_idle();
    while (foe_queue.size() != 0) @(posedge clk);
    repeat (SOLVE_WAIT) @(posedge clk);
    $display("Sent %0d points, checked %0d solves (%0d singular), including the",
             points_sent, solves_checked, singular_seen);
    $display("point-count limit, long output hold-off and four idle/stall mixes.");
    if (errors == 0 && foe_queue.size() == 0) begin
      $display("focus_of_expansion_lsq_tb OK");
    end else begin
      $display("focus_of_expansion_lsq_tb NOT OK");
    end
    $finish;
  end
endmodule
